// ===== rtl/cq_pkg.sv =====
package cq_pkg;

    // Field widths fixed by the item formats.
    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Command codes carried in the opcode field.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_DUMP_OLD = 3'd2,
        OP_DUMP_NEW = 3'd3,
        OP_DUMP_POS = 3'd4
    } t_opcode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] element;
        logic [SLOT_W-1:0]        slot;
        logic                     has_element;
        logic                     last;
    } t_out_item;

endpackage

// ===== rtl/cq_stream_if.sv =====
// Command channel into the queue.
interface cq_in_if;
    import cq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel out of the queue.
interface cq_out_if;
    import cq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/circular_queue_with_dump_core.sv =====
// Ring-buffer queue of signed 32-bit words with push, pop and three listing
// commands. Push and pop each answer with one result beat; unused opcodes
// are dropped. A dump accepts the command, then scans each stored element
// through the single read port of the storage and the shared index stepper,
// then delivers the final beat; back-pressure on the result channel stalls
// the scan and the final beat. The result of a push or pop sits in the output
// register while the next command is taken. Every dump holds each listed
// word back by one so that the final beat can carry the last marker.
// Storage is not cleared after reset; no clearing pass is needed since only
// occupied entries are read.
module circular_queue_with_dump_core #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cq_in_if.sink       i_in,
    cq_out_if.source    o_out
);
    import cq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_left, n_left;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic               r_pend_valid, n_pend_valid;
    logic [WORD_W-1:0]  r_pend_elem, n_pend_elem;
    logic [AW-1:0]      r_pend_slot, n_pend_slot;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               out_free;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_rdata;
    logic [AW-1:0]      step_in, step_out;
    logic               step_down;
    logic               match;

    cq_step #(.DEPTH(DEPTH)) u_step (
        .i_idx  (step_in),
        .i_down (step_down),
        .o_idx  (step_out)
    );

    // Read ahead at the next scan index so the read data matches r_idx.
    cq_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (step_out),
        .i_wdata (i_in.data.push_value),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // The stepper serves push and pop while idle and the scan otherwise.
    always_comb begin
        if (r_state == S_IDLE) begin
            step_in   = (i_in.data.opcode == OP_PUSH) ? r_tail : r_head;
            step_down = 1'b0;
        end else begin
            step_in   = r_idx;
            step_down = (r_op == OP_DUMP_NEW);
        end
    end

    // A word is listed unless the positive-only dump rejects it.
    assign match = (r_op != OP_DUMP_POS) || (!ram_rdata[WORD_W-1] && (ram_rdata != '0));

    // Sequencer: next state, queue indices and the result beat.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_tail       = r_tail;
        n_idx        = r_idx;
        n_left       = r_left;
        n_op         = r_op;
        n_pend_valid = r_pend_valid;
        n_pend_elem  = r_pend_elem;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        ram_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && out_free) begin
                    n_out.element     = '0;
                    n_out.slot        = '0;
                    n_out.has_element = 1'b0;
                    n_out.last        = 1'b1;
                    n_out.status      = STAT_OK;
                    unique case (i_in.data.opcode)
                        OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                n_tail  = step_out;
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_head = '0;
                                    n_tail = LAST_IDX;
                                end else begin
                                    n_head = step_out;
                                end
                            end
                        end
                        OP_DUMP_OLD, OP_DUMP_NEW, OP_DUMP_POS: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end else begin
                                n_op         = i_in.data.opcode;
                                n_idx        = (i_in.data.opcode == OP_DUMP_NEW) ?
                                               r_tail : r_head;
                                n_left       = r_count;
                                n_pend_valid = 1'b0;
                                n_state      = S_SCAN;
                            end
                        end
                        default: begin
                            // Unused opcodes are dropped without a result.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Hold the scan while a pending match cannot be released.
                if (!(match && r_pend_valid && !out_free)) begin
                    if (match) begin
                        if (r_pend_valid) begin
                            n_out_valid       = 1'b1;
                            n_out.status      = STAT_OK;
                            n_out.element     = r_pend_elem;
                            n_out.slot        = SLOT_W'(r_pend_slot);
                            n_out.has_element = 1'b1;
                            n_out.last        = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_elem  = ram_rdata;
                        n_pend_slot  = r_idx;
                    end
                    n_idx  = step_out;
                    n_left = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Close the dump with the held match or a no-match beat.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out.status      = STAT_OK;
                        n_out.element     = r_pend_elem;
                        n_out.slot        = SLOT_W'(r_pend_slot);
                        n_out.has_element = 1'b1;
                    end else begin
                        n_out.status      = STAT_NOMATCH;
                        n_out.element     = '0;
                        n_out.slot        = '0;
                        n_out.has_element = 1'b0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_head       <= '0;
            r_tail       <= LAST_IDX;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_op        <= n_op;
        r_pend_elem <= n_pend_elem;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end
endmodule

// ===== rtl/cq_step.sv =====
// Ring index stepper shared by push, pop and the dump scan.
module cq_step #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  logic                     i_down,
    output logic [$clog2(DEPTH)-1:0] o_idx
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // Step one slot forward or backward, wrapping at the ring ends.
    always_comb begin
        if (i_down) begin
            o_idx = (i_idx == '0) ? LAST_IDX : i_idx - AW'(1);
        end else begin
            o_idx = (i_idx == LAST_IDX) ? '0 : i_idx + AW'(1);
        end
    end
endmodule

// ===== rtl/cq_ram.sv =====
// Queue storage: one write port, one registered read port.
module cq_ram #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // Write and read in the same clocked block; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cq_checker.sv =====
// Port-level checks on the queue's command and result channels.
module cq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [2:0]          i_in_opcode,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cq_pkg::t_out_item   i_out_data
);
    import cq_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // No command is taken while a result waits.
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("command accepted while result stalled");

    // Push and pop answer with a single final beat in the next cycle.
    a_push_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_opcode == OP_PUSH || i_in_opcode == OP_POP)
        |=> i_out_valid && i_out_data.last && !i_out_data.has_element)
        else $error("push or pop did not give one final beat");

    // Beats without an element are final and carry zero payload.
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != STAT_OK || !i_out_data.has_element)
        |-> !i_out_data.has_element && i_out_data.last &&
            i_out_data.element == '0 && i_out_data.slot == '0)
        else $error("status beat with element data");
endmodule

bind circular_queue_with_dump_core cq_checker u_cq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.data.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
